>>> hdl/att_pkg.sv
`default_nettype none

package att_pkg;

  localparam int unsigned DEFAULT_SLOT_COUNT = 64;
  localparam int unsigned DEFAULT_ADDR_WIDTH = 32;
  localparam int unsigned DEFAULT_SIZE_WIDTH = 32;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NULL    = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_MISSING = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [31:0] alloc_size;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic [31:0] current_bytes;
    logic [31:0] peak_bytes;
    logic [31:0] alloc_total;
    logic [31:0] release_total;
    logic [6:0]  live_slots;
  } out_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic scan;
    logic present;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_null;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/allocation_tracking_table_unit.sv
`default_nettype none

// Tracks allocations in a table of SLOT_COUNT slots held in one slot memory with a single
// read port. After reset the table is cleared one slot a cycle with in_stall_o high. A
// request is then handled alone: the memory is walked one slot a cycle from slot 0 and
// the walk stops at the first free slot for an allocate or the first live matching slot
// for a release; a full table or an unknown address walks every slot, and a null
// address skips the walk. The next request is taken while a result still waits in the
// output register.
module allocation_tracking_table_unit #(
  parameter int unsigned SLOT_COUNT = att_pkg::DEFAULT_SLOT_COUNT,
  parameter int unsigned ADDR_WIDTH = att_pkg::DEFAULT_ADDR_WIDTH,
  parameter int unsigned SIZE_WIDTH = att_pkg::DEFAULT_SIZE_WIDTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire att_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output att_pkg::out_t     out_data_o
);

  att_pkg::cmd_t cmd;
  att_pkg::sts_t sts;

  att_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  att_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .ADDR_WIDTH (ADDR_WIDTH),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !cmd.take;

endmodule

`default_nettype wire

>>> hdl/att_ram.sv
`default_nettype none

module att_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                        wr_data_i,
  input  wire logic                                    rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                        rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/att_ctrl.sv
`default_nettype none

module att_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire att_pkg::sts_t sts_i,
  output att_pkg::cmd_t      cmd_o
);

  att_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      att_pkg::ST_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = att_pkg::ST_IDLE;
        end
      end
      att_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_null ? att_pkg::ST_DONE : att_pkg::ST_SCAN;
        end
      end
      att_pkg::ST_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = att_pkg::ST_DONE;
        end
      end
      att_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = att_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = att_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      att_pkg::ST_CLEAR: cmd_o.clear = 1'b1;
      att_pkg::ST_IDLE:  cmd_o.take = 1'b1;
      att_pkg::ST_SCAN:  cmd_o.scan = 1'b1;
      att_pkg::ST_DONE:  cmd_o.present = sts_i.out_free;
      default:           cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= att_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == att_pkg::ST_IDLE) && in_valid_i |=> (state_q != att_pkg::ST_IDLE))
    else $error("Accepted request did not leave the idle state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == att_pkg::ST_SCAN) && sts_i.scan_end |=> (state_q == att_pkg::ST_DONE))
    else $error("Finished search did not move on to the result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == att_pkg::ST_CLEAR) |-> !cmd_o.take)
    else $error("Request taken during the clearing pass.");

endmodule

`default_nettype wire

>>> hdl/att_datapath.sv
`default_nettype none

module att_datapath #(
  parameter int unsigned SLOT_COUNT = att_pkg::DEFAULT_SLOT_COUNT,
  parameter int unsigned ADDR_WIDTH = att_pkg::DEFAULT_ADDR_WIDTH,
  parameter int unsigned SIZE_WIDTH = att_pkg::DEFAULT_SIZE_WIDTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire att_pkg::cmd_t cmd_i,
  output att_pkg::sts_t      sts_o,
  input  wire logic          in_valid_i,
  input  wire att_pkg::in_t  in_data_i,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output att_pkg::out_t      out_data_o
);

  localparam int unsigned AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int unsigned SW = (SIZE_WIDTH < 32) ? SIZE_WIDTH : 32;
  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned WW = 1 + AW + SW;

  logic          kind_q;
  logic [AW-1:0] addr_q;
  logic [SW-1:0] size_q;

  logic [CW-1:0] iss_q, iss_d;
  logic [IW-1:0] chk_q, chk_d;
  logic          chk_vld_q, chk_vld_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [31:0]   alloc_q, alloc_d;
  logic [31:0]   rel_q, rel_d;
  logic [31:0]   total_q, total_d;
  logic [31:0]   peak_q, peak_d;
  logic [CW-1:0] live_q, live_d;
  logic [1:0]    status_q, status_d;
  logic [IW-1:0] index_q, index_d;
  logic          out_valid_q, out_valid_d;
  att_pkg::out_t out_q;

  logic          load;
  logic          issue;
  logic          hit;
  logic          last;
  logic          scan_end;
  logic          out_free;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [WW-1:0] wr_data;
  logic [WW-1:0] rd_data;
  logic          rd_live;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_size;
  logic [32:0]   sum;
  logic [31:0]   sum_sat;
  logic [31:0]   rd_size_ext;
  logic [31:0]   diff;

  att_ram #(
    .WIDTH (WW),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (issue),
    .rd_addr_i (iss_q[IW-1:0]),
    .rd_data_o (rd_data)
  );

  assign rd_live = rd_data[WW-1];
  assign rd_addr = rd_data[SW +: AW];
  assign rd_size = rd_data[SW-1:0];

  assign load     = cmd_i.take & in_valid_i;
  assign issue    = cmd_i.scan && (iss_q < CW'(SLOT_COUNT));
  assign hit      = chk_vld_q && ((kind_q == att_pkg::KIND_ALLOC) ? !rd_live
                                  : (rd_live && (rd_addr == addr_q)));
  assign last     = chk_vld_q && (chk_q == IW'(SLOT_COUNT - 1));
  assign scan_end = cmd_i.scan && (hit || last);
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.clear_last = (clr_q == CW'(SLOT_COUNT - 1));
  assign sts_o.in_null    = (in_data_i.address[AW-1:0] == '0);
  assign sts_o.scan_end   = scan_end;
  assign sts_o.out_free   = out_free;

  assign sum         = {1'b0, total_q} + 33'(size_q);
  assign sum_sat     = sum[32] ? '1 : sum[31:0];
  assign rd_size_ext = 32'(rd_size);
  assign diff        = (rd_size_ext >= total_q) ? '0 : (total_q - rd_size_ext);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = chk_q;
    wr_data = '0;
    if (cmd_i.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_q[IW-1:0];
    end else if (scan_end && hit) begin
      wr_en = 1'b1;
      if (kind_q == att_pkg::KIND_ALLOC) begin
        wr_data = {1'b1, addr_q, size_q};
      end else begin
        wr_data = {1'b0, {AW{1'b0}}, rd_size};
      end
    end
  end

  always_comb begin
    iss_d     = iss_q;
    chk_d     = chk_q;
    chk_vld_d = issue;
    clr_d     = clr_q;
    alloc_d   = alloc_q;
    rel_d     = rel_q;
    total_d   = total_q;
    peak_d    = peak_q;
    live_d    = live_q;
    status_d  = status_q;
    index_d   = index_q;
    if (cmd_i.clear) begin
      clr_d = clr_q + 1'b1;
    end
    if (load) begin
      iss_d    = '0;
      status_d = att_pkg::STATUS_NULL;
      index_d  = '0;
    end
    if (issue) begin
      iss_d = iss_q + 1'b1;
      chk_d = iss_q[IW-1:0];
    end
    if (scan_end) begin
      if (kind_q == att_pkg::KIND_ALLOC) begin
        alloc_d = alloc_q + 32'd1;
        total_d = sum_sat;
        if (sum_sat > peak_q) begin
          peak_d = sum_sat;
        end
        if (hit) begin
          live_d   = live_q + 1'b1;
          status_d = att_pkg::STATUS_OK;
          index_d  = chk_q;
        end else begin
          status_d = att_pkg::STATUS_FULL;
        end
      end else if (hit) begin
        total_d  = diff;
        rel_d    = rel_q + 32'd1;
        live_d   = live_q - 1'b1;
        status_d = att_pkg::STATUS_OK;
        index_d  = chk_q;
      end else begin
        status_d = att_pkg::STATUS_MISSING;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.present) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= in_data_i.kind;
      addr_q <= in_data_i.address[AW-1:0];
      size_q <= in_data_i.alloc_size[SW-1:0];
    end
    if (cmd_i.present) begin
      out_q.status        <= status_q;
      out_q.slot_index    <= 6'(index_q);
      out_q.current_bytes <= total_q;
      out_q.peak_bytes    <= peak_q;
      out_q.alloc_total   <= alloc_q;
      out_q.release_total <= rel_q;
      out_q.live_slots    <= 7'(live_q);
    end
    chk_q <= chk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q       <= '0;
      chk_vld_q   <= 1'b0;
      clr_q       <= '0;
      alloc_q     <= '0;
      rel_q       <= '0;
      total_q     <= '0;
      peak_q      <= '0;
      live_q      <= '0;
      status_q    <= att_pkg::STATUS_OK;
      index_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      iss_q       <= iss_d;
      chk_vld_q   <= chk_vld_d;
      clr_q       <= clr_d;
      alloc_q     <= alloc_d;
      rel_q       <= rel_d;
      total_q     <= total_d;
      peak_q      <= peak_d;
      live_q      <= live_d;
      status_q    <= status_d;
      index_q     <= index_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CW'(SLOT_COUNT))
    else $error("Live slot count exceeds the table size.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= peak_q)
    else $error("Byte total above the recorded peak.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(alloc_q) |-> $past(scan_end && (kind_q == att_pkg::KIND_ALLOC)))
    else $error("Allocate count moved outside an allocate search.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.present |-> out_free)
    else $error("Result loaded over one not yet taken.");

endmodule

`default_nettype wire

>>> sim/allocation_tracking_table_unit_test.sv
`default_nettype none

module allocation_tracking_table_unit_test;

  localparam int SLOTS = att_pkg::DEFAULT_SLOT_COUNT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  att_pkg::in_t in_data = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  att_pkg::out_t out_data;

  allocation_tracking_table_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Expected copy of the allocation table and its running totals.
  logic [31:0] tbl_addr [SLOTS];
  logic [31:0] tbl_size [SLOTS];
  logic        tbl_live [SLOTS];
  logic [31:0] alloc_count = '0;
  logic [31:0] release_count = '0;
  logic [31:0] bytes_in_use = '0;
  logic [31:0] bytes_peak = '0;
  logic [6:0]  slots_in_use = '0;

  att_pkg::in_t  event_queue [$];
  att_pkg::out_t pending_reports [$];
  logic [31:0] issued_addrs [$];

  int events_queued = 0;
  int events_accepted = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  logic req_taken = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_addr[i] = '0;
      tbl_size[i] = '0;
      tbl_live[i] = 1'b0;
    end
  end

  function automatic att_pkg::out_t account_event(att_pkg::in_t ev);
    att_pkg::out_t r;
    logic [32:0] sum;
    int hit;
    r = '0;
    hit = -1;
    if (ev.address == '0) begin
      r.status = att_pkg::STATUS_NULL;
    end else if (ev.kind == att_pkg::KIND_ALLOC) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && !tbl_live[i]) hit = i;
      end
      if (hit >= 0) begin
        tbl_addr[hit] = ev.address;
        tbl_size[hit] = ev.alloc_size;
        tbl_live[hit] = 1'b1;
        slots_in_use = slots_in_use + 7'd1;
        r.status = att_pkg::STATUS_OK;
        r.slot_index = hit[5:0];
      end else begin
        r.status = att_pkg::STATUS_FULL;
      end
      alloc_count = alloc_count + 32'd1;
      sum = {1'b0, bytes_in_use} + {1'b0, ev.alloc_size};
      bytes_in_use = sum[32] ? '1 : sum[31:0];
      if (bytes_in_use > bytes_peak) bytes_peak = bytes_in_use;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && tbl_live[i] && tbl_addr[i] == ev.address) hit = i;
      end
      if (hit >= 0) begin
        bytes_in_use = (tbl_size[hit] >= bytes_in_use) ? '0 : bytes_in_use - tbl_size[hit];
        tbl_live[hit] = 1'b0;
        tbl_addr[hit] = '0;
        slots_in_use = slots_in_use - 7'd1;
        release_count = release_count + 32'd1;
        r.status = att_pkg::STATUS_OK;
        r.slot_index = hit[5:0];
      end else begin
        r.status = att_pkg::STATUS_MISSING;
      end
    end
    r.current_bytes = bytes_in_use;
    r.peak_bytes = bytes_peak;
    r.alloc_total = alloc_count;
    r.release_total = release_count;
    r.live_slots = slots_in_use;
    return r;
  endfunction

  task automatic queue_event(logic kind, logic [31:0] addr, logic [31:0] size);
    att_pkg::in_t ev;
    ev.kind = kind;
    ev.address = addr;
    ev.alloc_size = size;
    event_queue.push_back(ev);
    events_queued++;
  endtask

  function automatic logic [31:0] fresh_addr();
    logic [31:0] a;
    do a = $urandom; while (a == '0);
    return a;
  endfunction

  function automatic logic [31:0] draw_size(bit wide);
    int roll;
    roll = $urandom_range(0, 99);
    if (wide) begin
      if (roll < 15) return '1;
      if (roll < 60) return $urandom;
      return $urandom_range(0, 4096);
    end
    if (roll < 5) return $urandom_range(0, 1048575);
    return $urandom_range(0, 65535);
  endfunction

  // Alternates between filling and draining stretches so that the table
  // regularly runs full and empties again.
  task automatic queue_random(int count, bit wide);
    int alloc_pct;
    int seg_left;
    int idx;
    logic [31:0] addr;
    alloc_pct = 20;
    seg_left = 0;
    repeat (count) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 180);
        alloc_pct = (alloc_pct == 85) ? 20 : 85;
      end
      seg_left--;
      if ($urandom_range(0, 99) < 3) begin
        queue_event(1'($urandom_range(0, 1)), '0, $urandom);
      end else if ($urandom_range(0, 99) < alloc_pct) begin
        if (issued_addrs.size() != 0 && $urandom_range(0, 9) == 0) begin
          addr = issued_addrs[$urandom_range(0, issued_addrs.size() - 1)];
        end else begin
          addr = fresh_addr();
        end
        issued_addrs.push_back(addr);
        queue_event(att_pkg::KIND_ALLOC, addr, draw_size(wide));
      end else begin
        if (issued_addrs.size() != 0 && $urandom_range(0, 9) != 0) begin
          idx = $urandom_range(0, issued_addrs.size() - 1);
          addr = issued_addrs[idx];
          issued_addrs.delete(idx);
        end else begin
          addr = fresh_addr();
        end
        queue_event(att_pkg::KIND_RELEASE, addr, $urandom);
      end
    end
  endtask

  task automatic wait_for_idle();
    while (events_accepted != events_queued || pending_reports.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (event_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= event_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    att_pkg::out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("allocation_tracking_table_unit_test: FAIL");
      $finish;
    end else begin
      req_taken <= rst_n && in_valid && !in_stall;
      if (rst_n && in_valid && !in_stall) begin
        pending_reports.push_back(account_event(in_data));
        events_accepted++;
      end
      if (rst_n && out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected report: status %0d slot %0d",
                                         out_data.status, out_data.slot_index);
        end else begin
          want = pending_reports.pop_front();
          if (want !== out_data) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Report mismatch, expected: status %0d slot %0d bytes %h peak %h",
                       want.status, want.slot_index, want.current_bytes, want.peak_bytes);
              $display("  allocs %h releases %h live %0d", want.alloc_total,
                       want.release_total, want.live_slots);
              $display("Report mismatch, actual:   status %0d slot %0d bytes %h peak %h",
                       out_data.status, out_data.slot_index, out_data.current_bytes,
                       out_data.peak_bytes);
              $display("  allocs %h releases %h live %0d", out_data.alloc_total,
                       out_data.release_total, out_data.live_slots);
            end
          end
        end
      end
    end
  end

  initial begin
    send_idle_pct = 11;
    recv_idle_pct = 82;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Null addresses, unknown releases, duplicate addresses and slot reuse.
    queue_event(att_pkg::KIND_ALLOC, '0, '1);
    queue_event(att_pkg::KIND_RELEASE, '0, 32'h0000_0000);
    queue_event(att_pkg::KIND_RELEASE, 32'hFFFF_FFFF, '0);
    queue_event(att_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_event(att_pkg::KIND_ALLOC, 32'h0000_0001, 32'h0000_0001);
    queue_event(att_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'h0000_1000);
    queue_event(att_pkg::KIND_RELEASE, 32'hFFFF_FFFF, '0);
    queue_event(att_pkg::KIND_ALLOC, 32'h8000_0000, 32'h0000_0010);
    queue_event(att_pkg::KIND_RELEASE, 32'hFFFF_FFFF, '1);
    queue_event(att_pkg::KIND_RELEASE, 32'hFFFF_FFFF, '0);
    queue_event(att_pkg::KIND_RELEASE, 32'h0000_0001, '0);
    queue_event(att_pkg::KIND_ALLOC, 32'h5555_5555, 32'h0000_00AA);
    queue_event(att_pkg::KIND_ALLOC, 32'hAAAA_AAAA, 32'h0000_5555);
    queue_event(att_pkg::KIND_RELEASE, 32'h5555_5555, '0);
    queue_event(att_pkg::KIND_RELEASE, 32'h5555_5555, '0);
    queue_event(att_pkg::KIND_RELEASE, 32'h8000_0000, '0);
    queue_event(att_pkg::KIND_RELEASE, 32'hAAAA_AAAA, '0);
    queue_random(640, 1'b0);
    wait_for_idle();

    send_idle_pct = 82;
    recv_idle_pct = 11;
    queue_random(640, 1'b0);
    wait_for_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    queue_random(600, 1'b0);
    wait_for_idle();

    // Saturation of the byte total, then releases that would take it below zero.
    queue_event(att_pkg::KIND_ALLOC, 32'h7000_0001, 32'hFFFF_FFFF);
    queue_event(att_pkg::KIND_ALLOC, 32'h7000_0002, 32'hFFFF_FFFF);
    queue_event(att_pkg::KIND_ALLOC, 32'h7000_0003, 32'h8000_0000);
    queue_event(att_pkg::KIND_RELEASE, 32'h7000_0001, '0);
    queue_event(att_pkg::KIND_RELEASE, 32'h7000_0002, '0);
    queue_event(att_pkg::KIND_RELEASE, 32'h7000_0003, '0);
    queue_random(60, 1'b1);
    wait_for_idle();

    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("allocation_tracking_table_unit_test: PASS");
    end else begin
      $display("allocation_tracking_table_unit_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
